// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define CPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cpg_pkg.sv =====
package cpg_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_W    = 9;
  localparam int OFFX_W      = RADIUS_W + 1;
  localparam int OFFY_W      = RADIUS_W + 2;
  localparam int DEC_W       = 14;
  localparam int POINT_W     = 12;
  localparam int CALC_W0     = (COORD_BITS + 2 > POINT_W) ? COORD_BITS + 2 : POINT_W;
  localparam int CALC_W      = (CALC_W0 > OFFY_W + 1) ? CALC_W0 : OFFY_W + 1;
  localparam int NPOINTS     = 8;
  localparam int IDX_W       = $clog2(NPOINTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // One octant position with its centre, handed from the front to the back.
  typedef struct packed {
    logic [COORD_BITS-1:0]    cx;
    logic [COORD_BITS-1:0]    cy;
    logic [OFFX_W-1:0]        ox;
    logic signed [OFFY_W-1:0] oy;
    logic                     done;
  } job_t;

endpackage

// ===== hw/rtl/circle_point_generator.sv =====
// Midpoint circle rasteriser with eight-way symmetry. A start beat
// (command 0) loads the centre and radius and yields the eight mirrored
// points of (0, radius); each step beat (command 1) advances the octant
// walk by one position and yields its eight points, the run's eighth point
// carrying last. The step that takes y below x marks every point of its run
// with done_res, and further steps yield nothing until the next start. A
// start always abandons any circle in progress. The front end takes one
// input beat per cycle, updating the walk state and placing the new position
// in a two-entry queue; the back end turns each queued position into eight
// output beats, one per cycle, so a stream of steps is paced by the
// single output port. A step that arrives when no circle is
// active is taken and dropped. The input stalls only while the queue is
// full, and the output register takes a new point in the same cycle as the
// one it holds is taken, so points leave at one per cycle when the receiver
// keeps up. Coordinates wrap to 12-bit two's complement.
module circle_point_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [cpg_pkg::COORD_BITS-1:0]     center_x,
  input  logic [cpg_pkg::COORD_BITS-1:0]     center_y,
  input  logic [cpg_pkg::RADIUS_W-1:0]       radius,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cpg_pkg::POINT_W-1:0] point_x,
  output logic signed [cpg_pkg::POINT_W-1:0] point_y,
  output logic                               last,
  output logic                               done_res
);
  import cpg_pkg::*;

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // The input is held off only when the queue has no room.
  assign in_stall = queue_full;

  cpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .command    (command),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  cpg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  cpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .last       (last),
    .done_res   (done_res)
  );

endmodule

// ===== hw/rtl/cpg_fifo.sv =====
`include "assert_macros.svh"

module cpg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cpg_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cpg_pkg::job_t head_job
);
  import cpg_pkg::*;

  job_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CPG_ASSERT(a_no_overflow, push |-> (!full || pop), "push into a full queue")
  `CPG_ASSERT(a_no_underflow, pop |-> head_valid, "pop from an empty queue")
  `CPG_ASSERT_ALWAYS(a_reset_empty, rst |=> !head_valid, "queue not empty after reset")

endmodule

// ===== hw/rtl/cpg_front.sv =====
`include "assert_macros.svh"

module cpg_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            command,
  input  logic [cpg_pkg::COORD_BITS-1:0]  center_x,
  input  logic [cpg_pkg::COORD_BITS-1:0]  center_y,
  input  logic [cpg_pkg::RADIUS_W-1:0]    radius,
  input  logic                            queue_full,
  output logic                            push,
  output cpg_pkg::job_t                   push_job
);
  import cpg_pkg::*;

  logic [COORD_BITS-1:0]    center_x_reg;
  logic [COORD_BITS-1:0]    center_y_reg;
  logic [OFFX_W-1:0]        offset_x;
  logic signed [OFFY_W-1:0] offset_y;
  logic [DEC_W-1:0]         decision;
  logic                     active;

  logic                     accept;
  logic                     is_start;
  logic [DEC_W-1:0]         dx;
  logic [DEC_W-1:0]         dy;
  logic [DEC_W-1:0]         dec_step;
  logic [DEC_W-1:0]         dec_start;
  logic [OFFX_W-1:0]        x_step;
  logic signed [OFFY_W-1:0] y_step;
  logic signed [OFFY_W-1:0] x_step_s;
  logic                     finished;

  assign accept   = in_valid && !queue_full;
  assign is_start = (command == CMD_START);

  always_comb begin
    dx        = DEC_W'(signed'({1'b0, offset_x}));
    dy        = DEC_W'(offset_y);
    dec_start = DEC_W'(3) - (DEC_W'(radius) << 1);
    x_step    = offset_x + 1'b1;
    // A negative decision keeps y; otherwise the step also moves y inwards.
    if (decision[DEC_W-1]) begin
      dec_step = decision + (dx << 2) + DEC_W'(6);
      y_step   = offset_y;
    end else begin
      dec_step = decision + ((dx - dy) << 2) + DEC_W'(10);
      y_step   = offset_y - OFFY_W'(1);
    end
    x_step_s = OFFY_W'(signed'({1'b0, x_step}));
    finished = (y_step < x_step_s);
  end

  always_comb begin
    push = accept && (is_start || active);
    if (is_start) begin
      push_job.cx   = center_x;
      push_job.cy   = center_y;
      push_job.ox   = '0;
      push_job.oy   = signed'(OFFY_W'(radius));
      push_job.done = 1'b0;
    end else begin
      push_job.cx   = center_x_reg;
      push_job.cy   = center_y_reg;
      push_job.ox   = x_step;
      push_job.oy   = y_step;
      push_job.done = finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_reg <= '0;
      center_y_reg <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      decision     <= '0;
      active       <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        center_x_reg <= center_x;
        center_y_reg <= center_y;
        offset_x     <= '0;
        offset_y     <= signed'(OFFY_W'(radius));
        decision     <= dec_start;
        active       <= 1'b1;
      end else if (active) begin
        offset_x <= x_step;
        offset_y <= y_step;
        decision <= dec_step;
        active   <= !finished;
      end
    end
  end

  `CPG_ASSERT(a_done_ends, (push && push_job.done) |=> !active,
              "circle still active after its final step")

endmodule

// ===== hw/rtl/cpg_back.sv =====
`include "assert_macros.svh"

module cpg_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  cpg_pkg::job_t                      head_job,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cpg_pkg::POINT_W-1:0] point_x,
  output logic signed [cpg_pkg::POINT_W-1:0] point_y,
  output logic                               last,
  output logic                               done_res
);
  import cpg_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic              out_load;
  logic              emit;
  logic              is_last;
  logic [CALC_W-1:0] h;
  logic [CALC_W-1:0] k;
  logic [CALC_W-1:0] xe;
  logic [CALC_W-1:0] ye;
  logic [CALC_W-1:0] a;
  logic [CALC_W-1:0] b;
  logic              neg_a;
  logic              neg_b;
  logic [CALC_W-1:0] px;
  logic [CALC_W-1:0] py;

  assign out_load = !out_valid || !out_stall;
  assign emit     = out_load && head_valid;
  assign is_last  = (idx == IDX_W'(NPOINTS - 1));
  assign pop      = emit && is_last;

  always_comb begin
    h  = CALC_W'(head_job.cx);
    k  = CALC_W'(head_job.cy);
    xe = CALC_W'(head_job.ox);
    ye = CALC_W'(signed'(head_job.oy));
    // The second half of the run mirrors across the diagonal.
    a  = idx[IDX_W-1] ? ye : xe;
    b  = idx[IDX_W-1] ? xe : ye;
    unique case (idx)
      3'd0:    begin neg_a = 1'b0; neg_b = 1'b0; end
      3'd1:    begin neg_a = 1'b0; neg_b = 1'b1; end
      3'd2:    begin neg_a = 1'b1; neg_b = 1'b1; end
      3'd3:    begin neg_a = 1'b1; neg_b = 1'b0; end
      3'd4:    begin neg_a = 1'b0; neg_b = 1'b0; end
      3'd5:    begin neg_a = 1'b1; neg_b = 1'b0; end
      3'd6:    begin neg_a = 1'b1; neg_b = 1'b1; end
      default: begin neg_a = 1'b0; neg_b = 1'b1; end
    endcase
    px = neg_a ? h - a : h + a;
    py = neg_b ? k - b : k + b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x  <= signed'(px[POINT_W-1:0]);
      point_y  <= signed'(py[POINT_W-1:0]);
      last     <= is_last;
      done_res <= head_job.done;
    end
  end

  `CPG_ASSERT(a_hold_head, (idx != '0) |-> head_valid, "run lost its queue entry midway")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the midpoint circle rasteriser. Input beats are offered at
// the falling edge and taken at the rising edge; every taken beat is run
// through a local octant-walk model, which queues the eight points it
// should yield, if any. Separate processes stall the output side at random
// and compare every point taken from the block with the oldest queued one.
module tb;

  import cpg_pkg::*;

  // One expected output beat.
  typedef struct {
    logic signed [POINT_W-1:0] px;
    logic signed [POINT_W-1:0] py;
    logic                      lst;
    logic                      dn;
  } circle_point_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      command = CMD_START;
  logic [COORD_BITS-1:0]     center_x = '0;
  logic [COORD_BITS-1:0]     center_y = '0;
  logic [RADIUS_W-1:0]       radius = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic                      last;
  logic                      done_res;

  // Local copy of the walk state: centre, offsets, decision value and
  // whether a circle is in progress.
  logic [COORD_BITS-1:0]     walk_cx = '0;
  logic [COORD_BITS-1:0]     walk_cy = '0;
  logic [OFFX_W-1:0]         walk_x = '0;
  logic signed [OFFY_W-1:0]  walk_y = '0;
  logic signed [DEC_W-1:0]   walk_dec = '0;
  bit                        walk_active = 1'b0;

  circle_point_t expected_points[$];

  int  mismatch_cnt = 0;
  int  hold_cnt = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_gaps_on = 1'b1;
  bit  pressure_on = 1'b0;

  circle_point_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last),
    .done_res  (done_res)
  );

  always #6 clk = ~clk;

  // Idle cycles before a beat; none at all while gaps are switched off.
  function automatic int draw_gap(bit on);
    return on ? $urandom_range(0, 13) : 0;
  endfunction

  // Queue the eight mirrored points of the current offsets, in the order
  // the block yields them, with last on the eighth.
  function automatic void queue_octants(bit fin);
    int            h, k, x, y;
    int            px[8];
    int            py[8];
    circle_point_t pt;
    h = walk_cx;
    k = walk_cy;
    x = walk_x;
    y = walk_y;
    px[0] = h + x; py[0] = k + y;
    px[1] = h + x; py[1] = k - y;
    px[2] = h - x; py[2] = k - y;
    px[3] = h - x; py[3] = k + y;
    px[4] = h + y; py[4] = k + x;
    px[5] = h - y; py[5] = k + x;
    px[6] = h - y; py[6] = k - x;
    px[7] = h + y; py[7] = k - x;
    for (int i = 0; i < NPOINTS; i++) begin
      pt.px  = POINT_W'(px[i]);
      pt.py  = POINT_W'(py[i]);
      pt.lst = (i == NPOINTS - 1);
      pt.dn  = fin;
      expected_points.push_back(pt);
    end
  endfunction

  // Advance the local walk by one taken beat and queue what it yields.
  function automatic void trace_circle_beat(cmd_t cmd, logic [COORD_BITS-1:0] cx,
                                            logic [COORD_BITS-1:0] cy,
                                            logic [RADIUS_W-1:0] r);
    int d, xi, yi;
    bit fin;
    if (cmd == CMD_START) begin
      walk_cx     = cx;
      walk_cy     = cy;
      walk_x      = '0;
      walk_y      = OFFY_W'(r);
      walk_dec    = DEC_W'(3 - 2 * int'(r));
      walk_active = 1'b1;
      queue_octants(1'b0);
      return;
    end
    // A step with no circle in progress is taken and dropped.
    if (!walk_active) return;
    d  = walk_dec;
    xi = walk_x;
    yi = walk_y;
    if (d < 0) begin
      d = d + 4 * xi + 6;
    end else begin
      d  = d + 4 * (xi - yi) + 10;
      yi = yi - 1;
    end
    xi       = xi + 1;
    walk_dec = DEC_W'(d);
    walk_x   = OFFX_W'(xi);
    walk_y   = OFFY_W'(yi);
    fin      = (yi < xi);
    if (fin) walk_active = 1'b0;
    queue_octants(fin);
  endfunction

  // Offer one input beat after a random gap and hold it until it is taken.
  // With no gap the valid stays high and only the payload moves on.
  task automatic send_beat(cmd_t cmd, logic [COORD_BITS-1:0] cx,
                           logic [COORD_BITS-1:0] cy, logic [RADIUS_W-1:0] r);
    int gap;
    gap = draw_gap(in_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command  = cmd;
    center_x = cx;
    center_y = cy;
    radius   = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    trace_circle_beat(cmd, cx, cy, r);
  endtask

  // A step beat whose unused fields carry random bits.
  task automatic send_step();
    send_beat(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              RADIUS_W'($urandom));
  endtask

  // The output side: the stall follows the hold counter, or the long
  // hold-off while the pressure test runs.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt  = hold_cnt - 1;
    end else begin
      out_stall = pressure_on;
    end
  end

  // Every point taken is compared with the oldest expected one, field by
  // field, and a fresh hold is drawn for the next beat.
  always @(posedge clk) begin
    circle_point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point (%0d, %0d)", point_x, point_y);
        mismatch_cnt++;
      end else begin
        e = expected_points.pop_front();
        if (point_x !== e.px) begin
          $error("point_x: expected %0d, got %0d", e.px, point_x);
          mismatch_cnt++;
        end
        if (point_y !== e.py) begin
          $error("point_y: expected %0d, got %0d", e.py, point_y);
          mismatch_cnt++;
        end
        if (last !== e.lst) begin
          $error("last: expected %0b, got %0b", e.lst, last);
          mismatch_cnt++;
        end
        if (done_res !== e.dn) begin
          $error("done_res: expected %0b, got %0b", e.dn, done_res);
          mismatch_cnt++;
        end
      end
      hold_cnt = draw_gap(out_gaps_on);
    end
  end

  // Steps straight after reset find no circle and must yield nothing.
  task automatic test_step_without_circle();
    send_step();
    send_step();
  endtask

  // A zero radius gives the centre eight times; the first step crosses the
  // diagonal at once and finishes, and a further step is dropped.
  task automatic test_zero_radius();
    send_beat(CMD_START, '0, '0, '0);
    send_step();
    send_step();
  endtask

  // Largest radius at both corners of the coordinate range, so the mirrored
  // points reach their largest and most negative values.
  task automatic test_radius_extremes();
    send_beat(CMD_START, '1, '1, '1);
    repeat (3) send_step();
    send_beat(CMD_START, '0, '0, '1);
    repeat (3) send_step();
  endtask

  // A start in the middle of a circle abandons it and begins afresh.
  task automatic test_restart_mid_circle();
    send_beat(CMD_START, 10'h2AA, 10'h155, 9'h12C);
    send_step();
    send_beat(CMD_START, 10'h155, 10'h2AA, 9'd1);
    send_step();
  endtask

  // A small circle walked to its end, with one step after done.
  task automatic test_small_circle_to_done();
    send_beat(CMD_START, 10'd100, 10'd200, 9'd6);
    while (walk_active) send_step();
    send_step();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back-to-back beats, so the block fills and stalls its input.
  task automatic test_output_pressure();
    in_gaps_on = 1'b0;
    fork
      begin
        @(posedge clk);
        pressure_on = 1'b1;
        repeat (300) @(posedge clk);
        pressure_on = 1'b0;
      end
    join_none
    send_beat(CMD_START, 10'd500, 10'd600, 9'd200);
    repeat (12) send_step();
    in_gaps_on = 1'b1;
  endtask

  // Mostly whole circles with random centres and mostly small radii, some
  // abandoned part-way by a new start, with idle steps as noise. Large
  // radii are always cut short to keep the run length in check.
  task automatic test_random_circles(int n_beats);
    int sent;
    int steps;
    int sel;
    int r;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) == 0) send_step();
      sel = $urandom_range(0, 9);
      if (sel < 7) r = $urandom_range(0, 24);
      else if (sel < 9) r = $urandom_range(25, 120);
      else r = $urandom_range(121, 511);
      send_beat(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                RADIUS_W'(r));
      sent++;
      if (r > 60) steps = $urandom_range(0, 8);
      else if ($urandom_range(0, 3) == 0) steps = $urandom_range(0, r);
      else steps = 1000;
      while (walk_active && steps > 0 && sent < n_beats) begin
        send_step();
        sent++;
        steps--;
      end
      if (!walk_active && $urandom_range(0, 2) == 0) send_step();
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_step_without_circle();
    test_zero_radius();
    test_radius_extremes();
    test_restart_mid_circle();
    test_small_circle_to_done();
    test_output_pressure();

    test_random_circles(260);
    // A stretch with both sides running flat out.
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_circles(50);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_random_circles(100);

    @(negedge clk);
    in_valid = 1'b0;

    // Drain what is still due, then give the block a little longer in case
    // something unexpected follows.
    waited = 0;
    while (expected_points.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      mismatch_cnt++;
    end

    if (mismatch_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cpg_pkg.sv
hw/rtl/cpg_fifo.sv
hw/rtl/cpg_front.sv
hw/rtl/cpg_back.sv
hw/rtl/circle_point_generator.sv
dv/tb.sv
